// ===== rtl/lsf_pkg.sv =====
package lsf_pkg;

  // Shared unit operation
  typedef enum logic {
    OP_MUL,
    OP_DIV
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_CHECK,
    ST_FINISH
  } state_t;

  // Fit steps, in the order the sequencer runs them
  typedef enum logic [2:0] {
    STEP_NSXX,
    STEP_SXSX,
    STEP_NSXY,
    STEP_SXSY,
    STEP_SYSXX,
    STEP_SXSXY,
    STEP_DIVW,
    STEP_DIVB
  } step_t;

  // Result status codes
  typedef enum logic [1:0] {
    FIT_OK    = 2'd0,
    FIT_DEGEN = 2'd1,
    FIT_SAT   = 2'd2
  } fit_status_t;

  // Control into the shared unit
  typedef struct packed {
    logic start;
    op_t  op;
  } mu_ctrl_t;

  // Status out of the shared unit
  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } mu_stat_t;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

endpackage

// ===== rtl/lsf_accum.sv =====
module lsf_accum import lsf_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int CW         = 11,
  parameter int SX_W       = 27,
  parameter int SXX_W      = 42
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    add,
  input  logic                    clear,
  input  logic signed [15:0]      x,
  input  logic signed [15:0]      y,
  output logic [CW-1:0]           count,
  output logic signed [SX_W-1:0]  sx,
  output logic signed [SX_W-1:0]  sy,
  output logic signed [SXX_W-1:0] sxx,
  output logic signed [SXX_W-1:0] sxy
);

  logic signed [31:0]      xx;
  logic signed [31:0]      xy;
  logic signed [SXX_W-1:0] xx_ext;
  logic signed [SXX_W-1:0] xy_ext;
  logic                    room;

  // Form the sample products and widen them to the sum width
  always_comb begin
    xx     = x * x;
    xy     = x * y;
    xx_ext = {{(SXX_W-32){xx[31]}}, xx};
    xy_ext = {{(SXX_W-32){xy[31]}}, xy};
    room   = count < CW'(MAX_POINTS);
  end

  // Accumulate kept samples, drop once the set is full, clear after a fit
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count <= '0;
      sx    <= '0;
      sy    <= '0;
      sxx   <= '0;
      sxy   <= '0;
    end else if (add && room) begin
      count <= count + CW'(1);
      sx    <= sx + {{CW{x[15]}}, x};
      sy    <= sy + {{CW{y[15]}}, y};
      sxx   <= sxx + xx_ext;
      sxy   <= sxy + xy_ext;
    end
  end

endmodule

// ===== rtl/lsf_muldiv.sv =====
module lsf_muldiv import lsf_pkg::*; #(
  parameter int W         = 86,
  parameter int MUL_STEPS = 42
) (
  input  logic          clk,
  input  logic          rst,
  input  mu_ctrl_t      ctrl,
  input  logic [W-1:0]  opa,
  input  logic [W-1:0]  opm,
  output mu_stat_t      stat,
  output logic [W-1:0]  result,
  output logic [31:0]   quo
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  op_t              op_r;
  logic [W-1:0]     acc;
  logic [W-1:0]     opa_r;
  logic [W-1:0]     opm_r;
  logic             ovf;
  logic [W-1:0]     shifted;
  logic [W-1:0]     base;
  logic [W-1:0]     addend;
  logic [W:0]       sum;
  logic             ge;

  // One adder serves both shift-add multiply and restoring divide
  always_comb begin
    shifted = {acc[W-2:0], opm_r[W-1]};
    if (op_r == OP_DIV) begin
      base   = shifted;
      addend = ~opa_r;
    end else begin
      base   = acc;
      addend = opm_r[0] ? opa_r : '0;
    end
    sum = {1'b0, base} + {1'b0, addend} + (W+1)'(op_r == OP_DIV);
    ge  = sum[W];
  end

  // Sequence the step count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= (ctrl.op == OP_DIV) ? CNT_W'(W) : CNT_W'(MUL_STEPS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Advance the datapath one bit per cycle while busy
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      op_r  <= ctrl.op;
      acc   <= '0;
      opa_r <= opa;
      opm_r <= opm;
      quo   <= '0;
      ovf   <= 1'b0;
    end else if (busy) begin
      if (op_r == OP_DIV) begin
        acc   <= ge ? sum[W-1:0] : shifted;
        opm_r <= {opm_r[W-2:0], 1'b0};
        quo   <= {quo[30:0], ge};
        ovf   <= ovf | quo[31];
      end else begin
        acc   <= sum[W-1:0];
        opa_r <= {opa_r[W-2:0], 1'b0};
        opm_r <= {1'b0, opm_r[W-1:1]};
      end
    end
  end

  assign result    = acc;
  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.ovf  = ovf;

endmodule

// ===== rtl/least_squares_line_fit.sv =====
// Samples without last_sample are accumulated as they arrive; in_ready stays high.
// A last_sample request starts the fit: six products and two divides on one shift-add /
// shift-subtract unit; a zero denominator after the first two products ends it as degenerate.
// in_ready is low for the whole fit.
// A new set may stream in while the result waits in the output register.
// Synchronous active-high rst clears the count, the sums, the sequencer and out_valid.
module least_squares_line_fit import lsf_pkg::*; #(
  parameter int MAX_POINTS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] sample_x,
  input  logic signed [15:0] sample_y,
  input  logic               last_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] slope,
  output logic signed [31:0] intercept,
  output logic [1:0]         fit_status
);

  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int SX_W  = 16 + CW;
  localparam int SXX_W = 31 + CW;
  localparam int W     = SX_W + SXX_W + 17;

  state_t             state;
  state_t             state_next;
  step_t              step;
  step_t              step_next;
  mu_ctrl_t           mu_ctrl;
  mu_stat_t           mu_stat;
  logic [W-1:0]       mu_a;
  logic [W-1:0]       mu_m;
  logic               op_neg;
  logic               neg_r;
  logic [W-1:0]       mu_res;
  logic [31:0]        mu_quo;
  logic               in_fire;
  logic               fin_go;

  logic [CW-1:0]           count;
  logic signed [SX_W-1:0]  sx;
  logic signed [SX_W-1:0]  sy;
  logic signed [SXX_W-1:0] sxx;
  logic signed [SXX_W-1:0] sxy;
  logic [SX_W-1:0]         sx_mag;
  logic [SX_W-1:0]         sy_mag;
  logic [SXX_W-1:0]        sxx_mag;
  logic [SXX_W-1:0]        sxy_mag;
  logic [W-1:0]            den_mag;
  logic [W-1:0]            numw_mag;
  logic [W-1:0]            numb_mag;

  logic [W-1:0]  hold;
  logic [W-1:0]  den;
  logic [W-1:0]  numw;
  logic [W-1:0]  numb;
  logic [W-1:0]  diff;
  logic [32:0]   q_sat;
  logic [31:0]   slope_q;
  logic [31:0]   icpt_q;
  logic          sat_w;
  logic          sat_b;
  logic          deg;

  // Clamp an unsigned quotient with its sign to signed 32 bits (Q16.16 slope, Q24.8 intercept); bit 32 flags a clamp
  function automatic logic [32:0] sat_quo(input logic [31:0] q, input logic ovf,
                                          input logic neg);
    logic        sat;
    logic [31:0] v;
    if (neg) begin
      sat = ovf || (q > Q_MIN);
      v   = sat ? Q_MIN : (~q + 32'd1);
    end else begin
      sat = ovf || q[31];
      v   = sat ? Q_MAX : q;
    end
    return {sat, v};
  endfunction

  assign in_fire = in_valid && in_ready;
  assign fin_go  = (state == ST_FINISH) && (!out_valid || out_ready);

  lsf_accum #(
    .MAX_POINTS (MAX_POINTS),
    .CW         (CW),
    .SX_W       (SX_W),
    .SXX_W      (SXX_W)
  ) u_accum (
    .clk   (clk),
    .rst   (rst),
    .add   (in_fire),
    .clear (fin_go),
    .x     (sample_x),
    .y     (sample_y),
    .count (count),
    .sx    (sx),
    .sy    (sy),
    .sxx   (sxx),
    .sxy   (sxy)
  );

  lsf_muldiv #(
    .W         (W),
    .MUL_STEPS (SXX_W)
  ) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mu_ctrl),
    .opa    (mu_a),
    .opm    (mu_m),
    .stat   (mu_stat),
    .result (mu_res),
    .quo    (mu_quo)
  );

  // Take magnitudes of the sums and of the fit terms
  always_comb begin
    sx_mag   = sx[SX_W-1] ? SX_W'(-sx) : SX_W'(sx);
    sy_mag   = sy[SX_W-1] ? SX_W'(-sy) : SX_W'(sy);
    sxx_mag  = sxx[SXX_W-1] ? SXX_W'(-sxx) : SXX_W'(sxx);
    sxy_mag  = sxy[SXX_W-1] ? SXX_W'(-sxy) : SXX_W'(sxy);
    den_mag  = den[W-1] ? (~den + W'(1)) : den;
    numw_mag = numw[W-1] ? (~numw + W'(1)) : numw;
    numb_mag = numb[W-1] ? (~numb + W'(1)) : numb;
  end

  // Select operands for the current step
  always_comb begin
    case (step)
      STEP_NSXX: begin
        mu_a   = W'(count);
        mu_m   = W'(sxx_mag);
        op_neg = sxx[SXX_W-1];
      end
      STEP_SXSX: begin
        mu_a   = W'(sx_mag);
        mu_m   = W'(sx_mag);
        op_neg = 1'b0;
      end
      STEP_NSXY: begin
        mu_a   = W'(count);
        mu_m   = W'(sxy_mag);
        op_neg = sxy[SXX_W-1];
      end
      STEP_SXSY: begin
        mu_a   = W'(sx_mag);
        mu_m   = W'(sy_mag);
        op_neg = sx[SX_W-1] ^ sy[SX_W-1];
      end
      STEP_SYSXX: begin
        mu_a   = W'(sy_mag);
        mu_m   = W'(sxx_mag);
        op_neg = sy[SX_W-1] ^ sxx[SXX_W-1];
      end
      STEP_SXSXY: begin
        mu_a   = W'(sx_mag);
        mu_m   = W'(sxy_mag);
        op_neg = sx[SX_W-1] ^ sxy[SXX_W-1];
      end
      STEP_DIVW: begin
        mu_a   = den_mag;
        mu_m   = {numw_mag[W-17:0], 16'd0};
        op_neg = numw[W-1] ^ den[W-1];
      end
      STEP_DIVB: begin
        mu_a   = den_mag;
        mu_m   = {numb_mag[W-9:0], 8'd0};
        op_neg = numb[W-1] ^ den[W-1];
      end
      default: begin
        mu_a   = '0;
        mu_m   = '0;
        op_neg = 1'b0;
      end
    endcase
  end

  // Hold state and step
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_NSXX;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Next state, unit launch and input handshake
  always_comb begin
    state_next    = state;
    step_next     = step;
    mu_ctrl.start = 1'b0;
    mu_ctrl.op    = (step == STEP_DIVW || step == STEP_DIVB) ? OP_DIV : OP_MUL;
    in_ready      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && last_sample) begin
          state_next = ST_LOAD;
          step_next  = STEP_NSXX;
        end
      end
      ST_LOAD: begin
        mu_ctrl.start = 1'b1;
        state_next    = ST_RUN;
      end
      ST_RUN: begin
        if (mu_stat.done) begin
          case (step)
            STEP_NSXX: begin
              step_next  = STEP_SXSX;
              state_next = ST_LOAD;
            end
            STEP_SXSX:  state_next = ST_CHECK;
            STEP_NSXY: begin
              step_next  = STEP_SXSY;
              state_next = ST_LOAD;
            end
            STEP_SXSY: begin
              step_next  = STEP_SYSXX;
              state_next = ST_LOAD;
            end
            STEP_SYSXX: begin
              step_next  = STEP_SXSXY;
              state_next = ST_LOAD;
            end
            STEP_SXSXY: begin
              step_next  = STEP_DIVW;
              state_next = ST_LOAD;
            end
            STEP_DIVW: begin
              step_next  = STEP_DIVB;
              state_next = ST_LOAD;
            end
            STEP_DIVB:  state_next = ST_FINISH;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_CHECK: begin
        if (den == '0) begin
          state_next = ST_FINISH;
        end else begin
          step_next  = STEP_NSXY;
          state_next = ST_LOAD;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Combine a finished product with the held one, clamp a finished quotient
  always_comb begin
    diff  = neg_r ? (hold + mu_res) : (hold - mu_res);
    q_sat = sat_quo(mu_quo, mu_stat.ovf, neg_r);
  end

  // Capture step results
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      neg_r <= op_neg;
    end
    if (state == ST_RUN && mu_stat.done) begin
      case (step)
        STEP_NSXX, STEP_NSXY, STEP_SYSXX: hold <= neg_r ? (~mu_res + W'(1)) : mu_res;
        STEP_SXSX:  den  <= diff;
        STEP_SXSY:  numw <= diff;
        STEP_SXSXY: numb <= diff;
        STEP_DIVW: begin
          slope_q <= q_sat[31:0];
          sat_w   <= q_sat[32];
        end
        STEP_DIVB: begin
          icpt_q <= q_sat[31:0];
          sat_b  <= q_sat[32];
        end
        default: hold <= hold;
      endcase
    end
    if (state == ST_CHECK) begin
      deg <= (den == '0);
      if (den == '0) begin
        slope_q <= '0;
        icpt_q  <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      slope     <= slope_q;
      intercept <= icpt_q;
      if (deg) begin
        fit_status <= FIT_DEGEN;
      end else if (sat_w || sat_b) begin
        fit_status <= FIT_SAT;
      end else begin
        fit_status <= FIT_OK;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_req_in_fit: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready)
    else $error("input request taken during a fit");

  a_start_idle_unit: assert property (@(posedge clk) disable iff (rst)
    mu_ctrl.start |-> !mu_stat.busy)
    else $error("shared unit launched while busy");

  a_clear_after_fit: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> (count == '0))
    else $error("sums not cleared after a fit");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fit_status == FIT_DEGEN) |-> (slope == '0 && intercept == '0))
    else $error("degenerate fit with nonzero result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("sample count beyond the set limit");
`endif

endmodule
